FILE: rtl/scc_pkg.sv
// Package for the strongly connected components block: word types and constants.
// No dependencies.
package scc_pkg;
   localparam int unsigned MaxVertices = 32;
   localparam int unsigned IdxW = 5;
   localparam int unsigned CntW = 6;

   typedef struct packed {
      logic       op;
      logic [4:0] edge_from;
      logic [4:0] edge_to;
   } req_word_type;

   typedef struct packed {
      logic [4:0] vertex;
      logic [4:0] component_number;
      logic       component_end;
      logic       run_last;
   } rsp_word_type;

   localparam logic OpEdge = 1'b0;
   localparam logic OpRun  = 1'b1;
endpackage

FILE: rtl/scc_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module scc_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/strongly_connected_components.sv
// Strongly connected components top level: edge loading, Kosaraju sequencer, result register.
// Depends on scc_pkg and scc_ram.
//
// An edge word is accepted, then both adjacency rows are read and written back with the
// new bit. Each stack step of a pass is a row read and a push or pop, the read going through
// the registered memory. Each start vertex of the first pass passes through a start state,
// and each finish entry of the second through a start and an emit state. A result held up
// on the output stalls the walk for as long as it waits. Adjacency rows are qualified by
// per-row valid bits, so the graph is cleared at the end of a run by resetting those bits.
module strongly_connected_components #(
   parameter int unsigned MAX_VERTICES = scc_pkg::MaxVertices
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scc_pkg::req_word_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output scc_pkg::rsp_word_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [5:0]           csr_data
);
   import scc_pkg::*;

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam int unsigned DW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERD, ST_EWR, ST_P1_START, ST_P1_RD, ST_P1_STEP,
      ST_P2_START, ST_P2_RD, ST_P2_STEP, ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [5:0]            vcount_ff;
   logic [MAX_VERTICES-1:0] fvalid_ff, rvalid_ff, visited_ff;
   logic [DW-1:0]         sp_ff, fin_ff, start_ff, nact_ff;
   logic [AW-1:0]         a_ff, b_ff;
   logic [4:0]            comp_ff;
   logic                  emitted_ff;
   logic                  rvld_ff;
   rsp_word_type          out_ff;
   rsp_word_type          hold_ff;

   // memories
   logic                    f_we, r_we, s_we, l_we;
   logic [AW-1:0]           f_wa, r_wa, f_ra, r_ra, s_wa, s_ra, l_wa, l_ra;
   logic [MAX_VERTICES-1:0] f_wd, r_wd, f_rd, r_rd;
   logic [AW-1:0]           s_wd, s_rd, l_wd, l_rd;

   scc_ram #(.Width(MAX_VERTICES), .Depth(MAX_VERTICES)) u_fwd (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));
   scc_ram #(.Width(MAX_VERTICES), .Depth(MAX_VERTICES)) u_rev (
      .clock, .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd), .rd_addr(r_ra), .rd_data(r_rd));
   scc_ram #(.Width(AW), .Depth(MAX_VERTICES)) u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));
   scc_ram #(.Width(AW), .Depth(MAX_VERTICES)) u_fin (
      .clock, .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra), .rd_data(l_rd));

   // top of stack is kept in a register so it is used without a memory read; stack memory holds the rest
   logic [AW-1:0]           top_ff;
   logic [MAX_VERTICES-1:0] active, frow, rrow, cand;
   logic [AW-1:0]           low;
   logic                    any;
   logic [DW-1:0]           nsat;
   logic                    out_free;
   logic                    out_go;
   rsp_word_type            out_word;

   always_comb begin
      nsat = (32'(vcount_ff) > MAX_VERTICES) ? DW'(MAX_VERTICES) : DW'(vcount_ff);
      for (int i = 0; i < MAX_VERTICES; i++) begin
         active[i] = (DW'(i) < nact_ff);
      end
      frow = fvalid_ff[a_ff] ? f_rd : '0;
      rrow = rvalid_ff[a_ff] ? r_rd : '0;
      cand = ((state_ff == ST_P1_STEP) ? frow : rrow) & active & ~visited_ff;
      any  = |cand;
      low  = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            low = AW'(i);
         end
      end
   end

   assign out_free = !rvld_ff || rsp_ready;
   assign out_go   = emitted_ff && (((state_ff == ST_EMIT) && !visited_ff[l_rd]) ||
                     ((state_ff == ST_P2_STEP) && any && out_free) ||
                     ((state_ff == ST_P2_START) && out_free && (start_ff == '0)));

   always_comb begin
      out_word = hold_ff;
      out_word.run_last = (state_ff == ST_P2_START);
   end

   always_comb begin
      f_we = 1'b0; r_we = 1'b0; s_we = 1'b0; l_we = 1'b0;
      f_wa = a_ff; r_wa = b_ff;
      f_wd = (fvalid_ff[a_ff] ? f_rd : '0) | (MAX_VERTICES'(1) << b_ff);
      r_wd = (rvalid_ff[b_ff] ? r_rd : '0) | (MAX_VERTICES'(1) << a_ff);
      f_ra = a_ff; r_ra = b_ff;
      s_wa = sp_ff[AW-1:0]; s_wd = top_ff;
      s_ra = sp_ff[AW-1:0] - AW'(1);
      l_wa = fin_ff[AW-1:0]; l_wd = top_ff;
      l_ra = start_ff[AW-1:0] - AW'(1);
      unique case (state_ff)
         ST_EWR: begin
            f_we = 1'b1; r_we = 1'b1;
         end
         ST_P1_RD, ST_P2_RD: begin
            f_ra = top_ff; r_ra = top_ff;
         end
         ST_P1_STEP: begin
            s_we = any;
            l_we = !any;
            s_ra = sp_ff[AW-1:0] - AW'(2);
         end
         ST_P2_STEP: begin
            s_we = any && out_free;
            s_ra = sp_ff[AW-1:0] - AW'(2);
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rvld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         vcount_ff  <= 6'd32;
         fvalid_ff  <= '0;
         rvalid_ff  <= '0;
         visited_ff <= '0;
         sp_ff      <= '0;
         fin_ff     <= '0;
         start_ff   <= '0;
         nact_ff    <= '0;
         comp_ff    <= '0;
         rvld_ff    <= 1'b0;
         emitted_ff <= 1'b0;
      end else begin
         if (out_go) begin
            out_ff  <= out_word;
            rvld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rvld_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  vcount_ff <= csr_data;
               end
               if (req_valid) begin
                  if (req_data.op == OpEdge) begin
                     a_ff     <= AW'(req_data.edge_from);
                     b_ff     <= AW'(req_data.edge_to);
                     state_ff <= (32'(req_data.edge_from) < MAX_VERTICES &&
                                  32'(req_data.edge_to) < MAX_VERTICES) ? ST_ERD : ST_IDLE;
                  end else begin
                     nact_ff    <= nsat;
                     visited_ff <= '0;
                     sp_ff      <= '0;
                     fin_ff     <= '0;
                     start_ff   <= '0;
                     state_ff   <= ST_P1_START;
                  end
               end
            end
            ST_ERD: state_ff <= ST_EWR;
            ST_EWR: begin
               fvalid_ff[a_ff] <= 1'b1;
               rvalid_ff[b_ff] <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_P1_START: begin
               if (start_ff >= nact_ff) begin
                  start_ff <= fin_ff;
                  visited_ff <= '0;
                  comp_ff <= '0;
                  emitted_ff <= 1'b0;
                  state_ff <= ST_P2_START;
               end else if (visited_ff[start_ff[AW-1:0]]) begin
                  start_ff <= start_ff + DW'(1);
               end else begin
                  top_ff <= start_ff[AW-1:0];
                  visited_ff[start_ff[AW-1:0]] <= 1'b1;
                  sp_ff <= DW'(1);
                  state_ff <= ST_P1_RD;
               end
            end
            ST_P1_RD: begin
               a_ff <= top_ff;
               state_ff <= ST_P1_STEP;
            end
            ST_P1_STEP: begin
               if (any) begin
                  top_ff <= low;
                  visited_ff[low] <= 1'b1;
                  sp_ff <= sp_ff + DW'(1);
                  state_ff <= ST_P1_RD;
               end else begin
                  fin_ff <= fin_ff + DW'(1);
                  sp_ff <= sp_ff - DW'(1);
                  if (sp_ff == DW'(1)) begin
                     start_ff <= start_ff + DW'(1);
                     state_ff <= ST_P1_START;
                  end else begin
                     top_ff <= s_rd;
                     state_ff <= ST_P1_RD;
                  end
               end
            end
            ST_P2_START: begin
               if (out_free) begin
                  if (start_ff == '0) begin
                     emitted_ff <= 1'b0;
                     fvalid_ff <= '0;
                     rvalid_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (visited_ff[l_rd]) begin
                  start_ff <= start_ff - DW'(1);
                  state_ff <= ST_P2_START;
               end else begin
                  hold_ff <= '{vertex: 5'(l_rd), component_number: comp_ff,
                               component_end: 1'b0, run_last: 1'b0};
                  emitted_ff <= 1'b1;
                  top_ff <= l_rd;
                  visited_ff[l_rd] <= 1'b1;
                  sp_ff <= DW'(1);
                  state_ff <= ST_P2_RD;
               end
            end
            ST_P2_RD: begin
               a_ff <= top_ff;
               state_ff <= ST_P2_STEP;
            end
            ST_P2_STEP: begin
               if (any) begin
                  if (out_free) begin
                     hold_ff <= '{vertex: 5'(low), component_number: comp_ff,
                                  component_end: 1'b0, run_last: 1'b0};
                     top_ff <= low;
                     visited_ff[low] <= 1'b1;
                     sp_ff <= sp_ff + DW'(1);
                  end
                  state_ff <= ST_P2_RD;
               end else begin
                  sp_ff <= sp_ff - DW'(1);
                  if (sp_ff == DW'(1)) begin
                     hold_ff.component_end <= 1'b1;
                     comp_ff <= comp_ff + 5'd1;
                     start_ff <= start_ff - DW'(1);
                     state_ff <= ST_P2_START;
                  end else begin
                     top_ff <= s_rd;
                     state_ff <= ST_P2_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
